FILE: design/pvau_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; imported by polyphonic_voice_allocator_unit.
`timescale 1ns / 1ps

package pvau_pkg;

  localparam int NUM_VOICES = 16;
  localparam int NUM_NOTES  = 128;
  localparam int VOICE_W    = 4;   // voice index width, fixed by the result field
  localparam int NOTE_W     = 7;
  localparam int POLY_W     = 5;
  localparam int MASK_W     = 16;

  localparam logic [POLY_W-1:0] POLY_MAX   = POLY_W'(NUM_VOICES);
  localparam logic [POLY_W-1:0] POLY_RESET = 5'd16;

  // register index taken from paddr[2]
  localparam logic REG_POLYPHONY = 1'b0;

  typedef enum logic [1:0] {
    FN_NOTE_ON  = 2'd0,
    FN_NOTE_OFF = 2'd1,
    FN_FINISHED = 2'd2,
    FN_ALL_OFF  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_IGNORE   = 3'd0,
    ACT_RETRIG   = 3'd1,
    ACT_START    = 3'd2,
    ACT_STEAL    = 3'd3,
    ACT_RELEASE  = 3'd4,
    ACT_FREE     = 3'd5,
    ACT_ALL_REL  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  function automatic logic [POLY_W-1:0] clamp_poly(input logic [POLY_W-1:0] v);
    logic [POLY_W-1:0] r;
    r = v;
    if (v == '0) r = POLY_W'(1);
    else if (v > POLY_MAX) r = POLY_MAX;
    return r;
  endfunction

endpackage

FILE: design/polyphonic_voice_allocator_unit.sv
// Voice allocator top level: voice state, note owner map and scan sequencer.
// Depends on pvau_pkg.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done_o high. The receiver cannot stall.
// For note-off, voice-finished, all-off and a retriggered note-on, the note
// owner map is read into a register at the accept edge, ST_LOOK decides and
// updates, and the result registers then show the result with busy low.
// A note-on that misses the map scans the voices one per cycle through a
// single compare step, up to and including the first idle one, or as many
// voices as the polyphony when none is idle.
// Configuration writes are taken at any time, but only while idle by contract.
module polyphonic_voice_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     func_i,
  input  logic [pvau_pkg::NOTE_W-1:0]    note_i,
  input  logic [6:0]                     velocity_i,
  input  logic [7:0]                     sample_id_i,
  input  logic [pvau_pkg::VOICE_W-1:0]   voice_sel_i,
  output logic                           done_o,
  output logic [2:0]                     action_o,
  output logic [pvau_pkg::VOICE_W-1:0]   voice_index_o,
  output logic [7:0]                     start_sample_o,
  output logic [6:0]                     start_velocity_o,
  output logic [pvau_pkg::MASK_W-1:0]    release_mask_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pvau_pkg::*;

  state_e state_q, state_d;

  logic [POLY_W-1:0] poly_q;

  // latched item
  func_e              func_q;
  logic [NOTE_W-1:0]  note_q;
  logic [6:0]         vel_q;
  logic [7:0]         smp_q;
  logic [VOICE_W-1:0] sel_q;

  // voice state
  logic [NUM_VOICES-1:0] active_q, active_d;
  logic [NUM_VOICES-1:0] rel_q, rel_d;
  logic [NOTE_W-1:0]     vnote_q [NUM_VOICES];

  // note owner map: valid bits in flops, owner index in memory
  logic [NUM_NOTES-1:0] ovalid_q;
  logic [VOICE_W-1:0]   owner_mem [NUM_NOTES];
  logic [VOICE_W-1:0]   own_rd_q;
  logic                 ovld_rd_q;

  // scan state
  logic [VOICE_W-1:0] cnt_q, cnt_d;
  logic               relf_q, relf_d;
  logic [VOICE_W-1:0] relidx_q, relidx_d;

  // result registers
  logic                 done_q;
  logic [2:0]           act_q;
  logic [VOICE_W-1:0]   vidx_q;
  logic [7:0]           osmp_q;
  logic [6:0]           ovel_q;
  logic [MASK_W-1:0]    mask_q;

  logic               accept;
  logic               cfg_wr;
  logic               emit;
  action_e            e_act;
  logic [VOICE_W-1:0] e_vidx;
  logic               e_started;
  logic [MASK_W-1:0]  e_mask;
  logic               do_start;
  logic [VOICE_W-1:0] start_idx;
  logic               owner_hit;
  logic               scan_last;
  logic               cur_rel;
  logic [NUM_VOICES-1:0] all_mask;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLYPHONY) ? {{(32-POLY_W){1'b0}}, poly_q} : 32'd0;

  // the stored owner index is always below the voice count at this width
  assign owner_hit = ovld_rd_q && (vnote_q[own_rd_q] == note_q) && active_q[own_rd_q];
  assign scan_last = ((POLY_W'(cnt_q) + POLY_W'(1)) == poly_q);
  assign cur_rel   = active_q[cnt_q] && rel_q[cnt_q];
  assign all_mask  = active_q & ~rel_q;

  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    rel_d     = rel_q;
    cnt_d     = cnt_q;
    relf_d    = relf_q;
    relidx_d  = relidx_q;
    emit      = 1'b0;
    e_act     = ACT_IGNORE;
    e_vidx    = '0;
    e_started = 1'b0;
    e_mask    = '0;
    do_start  = 1'b0;
    start_idx = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        case (func_q)
          FN_NOTE_ON: begin
            if (owner_hit) begin
              active_d[own_rd_q] = 1'b1;
              rel_d[own_rd_q]    = 1'b0;
              emit      = 1'b1;
              e_act     = ACT_RETRIG;
              e_vidx    = own_rd_q;
              e_started = 1'b1;
            end else begin
              cnt_d   = '0;
              relf_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
          FN_NOTE_OFF: begin
            emit = 1'b1;
            if (owner_hit && !rel_q[own_rd_q]) begin
              rel_d[own_rd_q] = 1'b1;
              e_act  = ACT_RELEASE;
              e_vidx = own_rd_q;
            end
          end
          FN_FINISHED: begin
            emit = 1'b1;
            if (active_q[sel_q]) begin
              active_d[sel_q] = 1'b0;
              rel_d[sel_q]    = 1'b0;
              e_act  = ACT_FREE;
              e_vidx = sel_q;
            end
          end
          FN_ALL_OFF: begin
            emit   = 1'b1;
            rel_d  = rel_q | all_mask;
            e_act  = ACT_ALL_REL;
            e_mask = MASK_W'(all_mask);
          end
          default: emit = 1'b1;
        endcase
        if (emit) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        // one voice per cycle: first idle voice wins, else first releasing one
        if (!active_q[cnt_q]) begin
          do_start  = 1'b1;
          start_idx = cnt_q;
          e_act     = ACT_START;
        end else begin
          if (cur_rel && !relf_q) begin
            relf_d   = 1'b1;
            relidx_d = cnt_q;
          end
          if (scan_last) begin
            if (relf_q || cur_rel) begin
              do_start  = 1'b1;
              start_idx = relf_q ? relidx_q : cnt_q;
              e_act     = ACT_STEAL;
            end else begin
              emit = 1'b1;
            end
          end else begin
            cnt_d = cnt_q + VOICE_W'(1);
          end
        end
        if (do_start) begin
          active_d[start_idx] = 1'b1;
          rel_d[start_idx]    = 1'b0;
          emit      = 1'b1;
          e_vidx    = start_idx;
          e_started = 1'b1;
        end
        if (emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      poly_q   <= clamp_poly(POLY_RESET);
      active_q <= '0;
      rel_q    <= '0;
      ovalid_q <= '0;
      cnt_q    <= '0;
      relf_q   <= 1'b0;
      relidx_q <= '0;
      done_q   <= 1'b0;
      act_q    <= ACT_IGNORE;
      vidx_q   <= '0;
      osmp_q   <= '0;
      ovel_q   <= '0;
      mask_q   <= '0;
      for (int i = 0; i < NUM_VOICES; i++) vnote_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      rel_q    <= rel_d;
      cnt_q    <= cnt_d;
      relf_q   <= relf_d;
      relidx_q <= relidx_d;
      done_q   <= emit;
      if (cfg_wr && paddr[2] == REG_POLYPHONY) poly_q <= clamp_poly(pwdata[POLY_W-1:0]);
      if (do_start) begin
        vnote_q[start_idx] <= note_q;
        ovalid_q[note_q]   <= 1'b1;
      end
      if (emit) begin
        act_q  <= e_act;
        vidx_q <= e_vidx;
        osmp_q <= e_started ? smp_q : 8'd0;
        ovel_q <= e_started ? vel_q : 7'd0;
        mask_q <= e_mask;
      end
    end
  end

  // item latch and registered map read at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_e'(func_i);
      note_q    <= note_i;
      vel_q     <= velocity_i;
      smp_q     <= sample_id_i;
      sel_q     <= voice_sel_i;
      own_rd_q  <= owner_mem[note_i];
      ovld_rd_q <= ovalid_q[note_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_start) owner_mem[note_q] <= start_idx;
  end

  assign done_o           = done_q;
  assign action_o         = act_q;
  assign voice_index_o    = vidx_q;
  assign start_sample_o   = osmp_q;
  assign start_velocity_o = ovel_q;
  assign release_mask_o   = mask_q;

endmodule

FILE: tb/polyphonic_voice_allocator_unit_tb.sv
// Self-checking testbench for polyphonic_voice_allocator_unit: directed rows, then random
// note traffic over several polyphony settings, checked by a voice tracker or typed rows.
// Depends on pvau_pkg and the design; no external files.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_unit_tb;
  import pvau_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DIR_N       = 25;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 94;
  localparam int HOT_N       = 20;

  typedef struct packed {
    func_e      fn;
    logic [6:0] note;
    logic [6:0] vel;
    logic [7:0] smp;
    logic [3:0] sel;
  } voice_cmd_t;

  typedef struct packed {
    action_e     act;
    logic [3:0]  vidx;
    logic [7:0]  smp;
    logic [6:0]  vel;
    logic [15:0] mask;
  } voice_evt_t;

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] poly;
    voice_cmd_t cmd;
    logic       typed;
    voice_evt_t want;
  } dir_row_t;

  localparam voice_evt_t EVT_NONE = '{ACT_IGNORE, 4'd0, 8'd0, 7'd0, 16'h0};
  localparam voice_cmd_t CMD_NONE = '{FN_NOTE_ON, 7'd0, 7'd0, 8'd0, 4'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [6:0]  note_i;
  logic [6:0]  velocity_i;
  logic [7:0]  sample_id_i;
  logic [3:0]  voice_sel_i;
  logic        done_o;
  logic [2:0]  action_o;
  logic [3:0]  voice_index_o;
  logic [7:0]  start_sample_o;
  logic [6:0]  start_velocity_o;
  logic [15:0] release_mask_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  polyphonic_voice_allocator_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .func_i, .note_i, .velocity_i, .sample_id_i, .voice_sel_i,
    .done_o, .action_o, .voice_index_o, .start_sample_o, .start_velocity_o,
    .release_mask_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // voice tracker state
  bit          trk_active [NUM_VOICES];
  bit          trk_rel    [NUM_VOICES];
  logic [6:0]  trk_note   [NUM_VOICES];
  bit          own_valid  [NUM_NOTES];
  int          own_voice  [NUM_NOTES];
  int          poly_lim;

  voice_evt_t  pending_events[$];
  logic [6:0]  hot_notes[HOT_N];
  int          idle_pct;
  int          errors;
  int          items_sent;
  int          results_seen;
  int          act_seen[8];
  int          quiet_cycles;

  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, 5'd0, '{FN_ALL_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b1,
      '{ACT_ALL_REL, 4'd0, 8'd0, 7'd0, 16'h0}},
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd60, 7'd0, 8'd0, 4'd0}, 1'b1, EVT_NONE},
    '{1'b0, 5'd0, '{FN_FINISHED, 7'd0, 7'd0, 8'd0, 4'd15}, 1'b1, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd0, 7'd127, 8'd255, 4'd0}, 1'b1,
      '{ACT_START, 4'd0, 8'd255, 7'd127, 16'h0}},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd127, 7'd0, 8'd0, 4'd15}, 1'b1,
      '{ACT_START, 4'd1, 8'd0, 7'd0, 16'h0}},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd0, 7'd5, 8'hAA, 4'd0}, 1'b1,
      '{ACT_RETRIG, 4'd0, 8'hAA, 7'd5, 16'h0}},
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b1,
      '{ACT_RELEASE, 4'd0, 8'd0, 7'd0, 16'h0}},
    // already releasing, then a note with no owner
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b1, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd64, 7'd0, 8'd0, 4'd0}, 1'b1, EVT_NONE},
    '{1'b0, 5'd0, '{FN_ALL_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b1,
      '{ACT_ALL_REL, 4'd0, 8'd0, 7'd0, 16'h0002}},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd64, 7'h55, 8'h5A, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_FINISHED, 7'd0, 7'd0, 8'd0, 4'd2}, 1'b1,
      '{ACT_FREE, 4'd2, 8'd0, 7'd0, 16'h0}},
    '{1'b0, 5'd0, '{FN_FINISHED, 7'd0, 7'd0, 8'd0, 4'd2}, 1'b1, EVT_NONE},
    // owner went idle
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd64, 7'd0, 8'd0, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd64, 7'h2A, 8'hA5, 4'd0}, 1'b0, EVT_NONE},
    // polyphony of zero acts as one: steal, then drop
    '{1'b1, 5'd0, CMD_NONE, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd10, 7'h7F, 8'h0F, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd11, 7'h33, 8'h44, 4'd0}, 1'b1, EVT_NONE},
    // owner now plays another note
    '{1'b0, 5'd0, '{FN_NOTE_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b0, EVT_NONE},
    // retrigger works above the limit
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd127, 7'd1, 8'd1, 4'd0}, 1'b0, EVT_NONE},
    '{1'b1, 5'd31, CMD_NONE, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_FINISHED, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'd3, 7'h15, 8'h3C, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_ALL_OFF, 7'd0, 7'd0, 8'd0, 4'd0}, 1'b0, EVT_NONE},
    '{1'b0, 5'd0, '{FN_NOTE_ON, 7'h55, 7'h2A, 8'h55, 4'd0}, 1'b0, EVT_NONE}
  };

  // Work out the result of one command and update the tracked voice state.
  function automatic voice_evt_t track_voices(input voice_cmd_t c);
    voice_evt_t e;
    int         o;
    bit         found;
    e = EVT_NONE;
    found = 1'b0;
    case (c.fn)
      FN_NOTE_ON: begin
        o = own_voice[c.note];
        if (own_valid[c.note] && trk_note[o] == c.note && trk_active[o]) begin
          trk_rel[o] = 1'b0;
          e.act = ACT_RETRIG;
          e.vidx = 4'(o);
        end else begin
          for (int v = 0; v < poly_lim && !found; v++) begin
            if (!trk_active[v]) begin
              found = 1'b1;
              e.vidx = 4'(v);
              e.act = ACT_START;
            end
          end
          for (int v = 0; v < poly_lim && !found; v++) begin
            if (trk_active[v] && trk_rel[v]) begin
              found = 1'b1;
              e.vidx = 4'(v);
              e.act = ACT_STEAL;
            end
          end
          if (found) begin
            trk_active[e.vidx] = 1'b1;
            trk_rel[e.vidx] = 1'b0;
            trk_note[e.vidx] = c.note;
            own_valid[c.note] = 1'b1;
            own_voice[c.note] = e.vidx;
          end
        end
        if (e.act != ACT_IGNORE) begin
          e.smp = c.smp;
          e.vel = c.vel;
        end
      end
      FN_NOTE_OFF: begin
        o = own_voice[c.note];
        if (own_valid[c.note] && trk_note[o] == c.note && trk_active[o] && !trk_rel[o]) begin
          trk_rel[o] = 1'b1;
          e.act = ACT_RELEASE;
          e.vidx = 4'(o);
        end
      end
      FN_FINISHED: begin
        if (trk_active[c.sel]) begin
          trk_active[c.sel] = 1'b0;
          trk_rel[c.sel] = 1'b0;
          e.act = ACT_FREE;
          e.vidx = c.sel;
        end
      end
      default: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (trk_active[v] && !trk_rel[v]) begin
            trk_rel[v] = 1'b1;
            e.mask[v] = 1'b1;
          end
        end
        e.act = ACT_ALL_REL;
      end
    endcase
    return e;
  endfunction

  // Mostly plausible traffic: a pool of hot notes so that retriggers and
  // releases land, and finishes aimed at voices that are playing.
  function automatic voice_cmd_t roll_cmd();
    voice_cmd_t c;
    int         r;
    int         base;
    r = $urandom_range(99);
    c.fn   = (r < 45) ? FN_NOTE_ON : (r < 73) ? FN_NOTE_OFF :
             (r < 93) ? FN_FINISHED : FN_ALL_OFF;
    c.note = ($urandom_range(99) < 75) ? hot_notes[$urandom_range(HOT_N-1)] : 7'($urandom);
    c.vel  = 7'($urandom);
    c.smp  = 8'($urandom);
    c.sel  = 4'($urandom);
    if (c.fn == FN_FINISHED && $urandom_range(99) < 65) begin
      base = $urandom_range(NUM_VOICES-1);
      for (int k = 0; k < NUM_VOICES; k++) begin
        if (trk_active[(base + k) % NUM_VOICES]) begin
          c.sel = 4'((base + k) % NUM_VOICES);
          break;
        end
      end
    end
    return c;
  endfunction

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_events.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [4:0] val);
    settle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POLYPHONY, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FFE0) | 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    poly_lim = (val == 5'd0) ? 1 : (val > NUM_VOICES) ? NUM_VOICES : int'(val);
  endtask

  task automatic send_cmd(input voice_cmd_t c, input logic typed, input voice_evt_t want);
    voice_evt_t e;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start       <= 1'b1;
    func_i      <= c.fn;
    note_i      <= c.note;
    velocity_i  <= c.vel;
    sample_id_i <= c.smp;
    voice_sel_i <= c.sel;
    do @(posedge clk_i); while (busy);
    e = track_voices(c);
    pending_events.push_back(typed ? want : e);
    items_sent++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker and stall watchdog
  always @(posedge clk_i) begin
    voice_evt_t w;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        act_seen[action_o]++;
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result, action %0d voice %0d", $time, action_o,
                   voice_index_o);
          errors++;
        end else begin
          w = pending_events.pop_front();
          check_field("action", w.act, action_o);
          check_field("voice_index", w.vidx, voice_index_o);
          check_field("start_sample", w.smp, start_sample_o);
          check_field("start_velocity", w.vel, start_velocity_o);
          check_field("release_mask", w.mask, release_mask_o);
        end
      end
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("** polyphonic_voice_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0] poly_plan[PHASES];
    int         idle_plan[3];
    start       = 1'b0;
    func_i      = '0;
    note_i      = '0;
    velocity_i  = '0;
    sample_id_i = '0;
    voice_sel_i = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    poly_lim     = NUM_VOICES;
    foreach (act_seen[i]) act_seen[i] = 0;
    foreach (trk_active[v]) begin
      trk_active[v] = 1'b0;
      trk_rel[v] = 1'b0;
      trk_note[v] = '0;
    end
    foreach (own_valid[n]) begin
      own_valid[n] = 1'b0;
      own_voice[n] = 0;
    end
    poly_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'($urandom), 5'd16};
    idle_plan = '{0, 48, 10};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].is_cfg) write_poly(dir_rows[i].poly);
      else send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_poly(poly_plan[ph]);
      idle_pct = idle_plan[ph % 3];
      foreach (hot_notes[k]) hot_notes[k] = 7'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(39) == 0) settle();
        send_cmd(roll_cmd(), 1'b0, EVT_NONE);
      end
    end

    settle();
    repeat (24) @(posedge clk_i);
    $display("Ran %0d items, %0d results over %0d polyphony settings and three idle mixes.",
             items_sent, results_seen, PHASES + 2);
    $display("Seen: %0d starts, %0d steals, %0d retriggers, %0d releases, %0d frees, %0d ignored.",
             act_seen[ACT_START], act_seen[ACT_STEAL], act_seen[ACT_RETRIG],
             act_seen[ACT_RELEASE], act_seen[ACT_FREE], act_seen[ACT_IGNORE]);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("** polyphonic_voice_allocator_unit: PASSED **");
    end else begin
      $display("** polyphonic_voice_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pvau_pkg.sv
design/polyphonic_voice_allocator_unit.sv
tb/polyphonic_voice_allocator_unit_tb.sv
